/* rtl/sss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    // Parenthesis depth counter width.
    localparam int DEPTH_BITS = 8;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // Reported lexer codes.
    localparam logic [1:0] LX_SCAN  = 2'd0;
    localparam logic [1:0] LX_QUOTE = 2'd1;
    localparam logic [1:0] LX_LINEC = 2'd2;
    localparam logic [1:0] LX_BLOCK = 2'd3;

    // Copy-mode marker line progress.
    localparam logic [1:0] MK_EMPTY = 2'd0;
    localparam logic [1:0] MK_SLASH = 2'd1;
    localparam logic [1:0] MK_DOT   = 2'd2;
    localparam logic [1:0] MK_OTHER = 2'd3;

    typedef enum logic [3:0] {
        SC_SCAN  = 4'b0001,
        SC_QUOTE = 4'b0010,
        SC_LINEC = 4'b0100,
        SC_BLOCK = 4'b1000
    } t_scan_state;

    typedef struct packed {
        t_scan_state           scan;
        logic [DEPTH_BITS-1:0] depth;
        logic [7:0]            prior;
        logic [7:0]            quote;
        logic                  esc;
    } t_sql_state;

    typedef struct packed {
        logic       slash_odd;
        logic [1:0] marker;
    } t_copy_state;

    typedef struct packed {
        logic stmt_end;
        logic ovf;
    } t_sql_flags;

    typedef struct packed {
        logic line_end;
        logic done;
    } t_copy_flags;

    function automatic logic [1:0] scan_code(input t_scan_state s);
        logic [1:0] c;
        case (s)
            SC_SCAN:  c = LX_SCAN;
            SC_QUOTE: c = LX_QUOTE;
            SC_LINEC: c = LX_LINEC;
            SC_BLOCK: c = LX_BLOCK;
            default:  c = LX_SCAN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/sss_sql_lexer.sv */
`timescale 1ns / 1ps
`default_nettype none

module sss_sql_lexer (
    input  wire sss_pkg::t_sql_state i_cur,
    input  wire logic [7:0]          i_byte,
    output sss_pkg::t_sql_state      o_next,
    output sss_pkg::t_sql_flags      o_flags
);
    import sss_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    always_comb begin
        o_next  = i_cur;
        o_flags = '0;
        case (i_cur.scan)
            SC_SCAN: begin
                if (i_byte == CH_SEMI && i_cur.depth == '0) begin
                    o_flags.stmt_end = 1'b1;
                end else if (i_byte inside {CH_DQUOTE, CH_SQUOTE}) begin
                    o_next.scan  = SC_QUOTE;
                    o_next.quote = i_byte;
                    o_next.esc   = 1'b0;
                end else if (i_byte == CH_DASH && i_cur.prior == CH_DASH) begin
                    o_next.scan = SC_LINEC;
                end else if (i_byte == CH_STAR && i_cur.prior == CH_SLASH) begin
                    o_next.scan = SC_BLOCK;
                end else if (i_byte == CH_LPAR) begin
                    if (i_cur.depth == DEPTH_MAX) begin
                        o_flags.ovf = 1'b1;
                    end else begin
                        o_next.depth = i_cur.depth + DEPTH_BITS'(1);
                    end
                end else if (i_byte == CH_RPAR) begin
                    if (i_cur.depth == '0) begin
                        o_flags.ovf = 1'b1;
                    end else begin
                        o_next.depth = i_cur.depth - DEPTH_BITS'(1);
                    end
                end
            end
            SC_LINEC: begin
                if (i_byte == CH_NL) begin
                    o_next.scan = SC_SCAN;
                end
            end
            SC_BLOCK: begin
                if (i_cur.prior == CH_STAR && i_byte == CH_SLASH) begin
                    o_next.scan = SC_SCAN;
                end
            end
            SC_QUOTE: begin
                if (!i_cur.esc && i_cur.quote == i_byte) begin
                    o_next.scan = SC_SCAN;
                end else if (i_byte == CH_BSLASH) begin
                    // a run of backslashes toggles the escape
                    o_next.esc = (i_cur.prior == CH_BSLASH) ? ~i_cur.esc : 1'b1;
                end else begin
                    o_next.esc = 1'b0;
                end
            end
            default: begin
                o_next.scan = SC_SCAN;
            end
        endcase
        o_next.prior = i_byte;
    end

endmodule

`default_nettype wire

/* rtl/sss_copy_line.sv */
`timescale 1ns / 1ps
`default_nettype none

module sss_copy_line (
    input  wire sss_pkg::t_copy_state i_cur,
    input  wire logic [7:0]           i_byte,
    output sss_pkg::t_copy_state      o_next,
    output sss_pkg::t_copy_flags      o_flags
);
    import sss_pkg::*;

    always_comb begin
        o_next  = i_cur;
        o_flags = '0;
        if (i_byte == CH_NL && !i_cur.slash_odd) begin
            o_flags.line_end = 1'b1;
            o_flags.done     = (i_cur.marker == MK_DOT);
            o_next.marker    = MK_EMPTY;
            o_next.slash_odd = 1'b0;
        end else if (i_byte == CH_BSLASH) begin
            o_next.slash_odd = ~i_cur.slash_odd;
            o_next.marker    = (i_cur.marker == MK_EMPTY) ? MK_SLASH : MK_OTHER;
        end else begin
            // escaped newline lands here too: line is no longer the marker
            o_next.slash_odd = 1'b0;
            o_next.marker    = (i_byte == CH_DOT && i_cur.marker == MK_SLASH) ?
                               MK_DOT : MK_OTHER;
        end
    end

endmodule

`default_nettype wire

/* rtl/sql_statement_splitter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// SQL statement splitter.
// Input channel (i_in_valid / o_in_ready): one request per script byte, or a
// copy-mode entry request when i_cmd is high. Output channel (o_out_valid /
// i_out_ready): exactly one result per request, in order.
// A request is captured in an input register; the lexer and copy-line logic
// then update the block state and load the result register once it is free.
// Throughput: one request per cycle, sustained, as long as the receiver
// takes results.
// The rate is set by the single state update per byte in the lexer path.
// When the receiver stalls, the result register holds and the input register
// holds one more request; o_in_ready drops only when both are full.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// state to normal SQL scanning at depth zero, copy mode off.
// o_copy_active and o_lexer_state report the state after the request.

module sql_statement_splitter_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_chunk_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_statement_end,
    output logic            o_copy_line_end,
    output logic            o_copy_done,
    output logic            o_copy_active,
    output logic [1:0]      o_lexer_state,
    output logic            o_depth_overflow,
    output logic            o_chunk_last
);
    import sss_pkg::*;

    // input register
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // block state
    logic        r_copy_mode, n_copy_mode;
    t_sql_state  r_sql, n_sql;
    t_copy_state r_cp, n_cp;

    t_sql_state  lx_next;
    t_sql_flags  lx_flags;
    t_copy_state cp_next;
    t_copy_flags cp_flags;

    logic w_advance;

    sss_sql_lexer u_lexer (
        .i_cur   (r_sql),
        .i_byte  (r_in_byte),
        .o_next  (lx_next),
        .o_flags (lx_flags)
    );

    sss_copy_line u_copy (
        .i_cur   (r_cp),
        .i_byte  (r_in_byte),
        .o_next  (cp_next),
        .o_flags (cp_flags)
    );

    // result register frees when empty or being taken
    assign w_advance  = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_comb begin
        n_copy_mode = r_copy_mode;
        n_sql       = r_sql;
        n_cp        = r_cp;
        if (r_in_cmd) begin
            // entering copy mode clears the line tracking; re-entry is a no-op
            n_copy_mode = 1'b1;
            if (!r_copy_mode) begin
                n_cp = '0;
            end
        end else if (r_copy_mode) begin
            n_cp = cp_next;
            if (cp_flags.done) begin
                n_copy_mode = 1'b0;
            end
        end else begin
            n_sql = lx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            o_out_valid <= 1'b0;
            r_copy_mode <= 1'b0;
            r_sql       <= '{scan: SC_SCAN, depth: '0, prior: '0, quote: '0, esc: 1'b0};
            r_cp        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                o_out_valid <= 1'b1;
                r_copy_mode <= n_copy_mode;
                r_sql       <= n_sql;
                r_cp        <= n_cp;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_data_byte;
            r_in_last <= i_chunk_end;
        end
        if (w_advance) begin
            o_out_byte       <= r_in_cmd ? 8'h00 : r_in_byte;
            o_statement_end  <= !r_in_cmd && !r_copy_mode && lx_flags.stmt_end;
            o_depth_overflow <= !r_in_cmd && !r_copy_mode && lx_flags.ovf;
            o_copy_line_end  <= !r_in_cmd && r_copy_mode && cp_flags.line_end;
            o_copy_done      <= !r_in_cmd && r_copy_mode && cp_flags.done;
            o_copy_active    <= n_copy_mode;
            o_lexer_state    <= scan_code(n_sql.scan);
            o_chunk_last     <= r_in_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_closes_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_copy_done |-> o_copy_line_end && !o_copy_active)
        else $error("copy done without line end or with copy still active");

    a_stmt_end_semi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_statement_end |->
            o_out_byte == CH_SEMI && !o_copy_active && o_lexer_state == LX_SCAN)
        else $error("statement end on a non-semicolon or outside scan");

    a_ovf_paren: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth_overflow |->
            o_out_byte == CH_LPAR || o_out_byte == CH_RPAR)
        else $error("depth overflow on a non-parenthesis byte");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte))
        else $error("pending request lost from input register");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import sss_pkg::*;

    // Cycles without any accepted request or result before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 3000;
    // Drain margin after the last result.
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned TARGET_REQS = 1450;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
        logic       chunk;
    } t_req;

    typedef struct {
        logic [7:0] out_byte;
        logic       stmt_end;
        logic       line_end;
        logic       done;
        logic       copy_act;
        logic [1:0] lex;
        logic       ovf;
        logic       last;
    } t_split_res;

    // DUT connections; every input starts at a known value.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_cmd = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_chunk_end = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_statement_end;
    logic       o_copy_line_end;
    logic       o_copy_done;
    logic       o_copy_active;
    logic [1:0] o_lexer_state;
    logic       o_depth_overflow;
    logic       o_chunk_last;

    sql_statement_splitter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_chunk_end      (i_chunk_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_statement_end  (o_statement_end),
        .o_copy_line_end  (o_copy_line_end),
        .o_copy_done      (o_copy_done),
        .o_copy_active    (o_copy_active),
        .o_lexer_state    (o_lexer_state),
        .o_depth_overflow (o_depth_overflow),
        .o_chunk_last     (o_chunk_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Splitter predictor state: SQL lexer plus copy-line tracker.
    // ------------------------------------------------------------------
    logic                  copy_on = 1'b0;
    logic [1:0]            lex_mode = LX_SCAN;
    logic [DEPTH_BITS-1:0] nest_depth = '0;
    logic [7:0]            last_sql_byte = 8'h00;
    logic [7:0]            quote_char = 8'h00;
    logic                  quote_esc = 1'b0;
    logic                  bs_odd = 1'b0;
    logic [1:0]            marker_step = MK_EMPTY;

    t_req       pending_reqs[$];
    t_split_res expected_results[$];

    int unsigned reqs_queued = 0;
    int unsigned reqs_taken = 0;
    int unsigned results_seen = 0;
    int unsigned stmt_ends_seen = 0;
    int unsigned copy_lines_seen = 0;
    int unsigned copy_exits_seen = 0;
    int unsigned overflows_seen = 0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned cycle_cnt = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          req_took = 1'b0;
    bit          calm = 1'b0;

    // Expected result of one request; advances the predictor state.
    function automatic t_split_res predict_split(input logic cmd, input logic [7:0] b,
                                                 input logic last);
        t_split_res r;
        r.out_byte = 8'h00;
        r.stmt_end = 1'b0;
        r.line_end = 1'b0;
        r.done     = 1'b0;
        r.ovf      = 1'b0;
        if (cmd) begin
            // Copy entry: line tracker restarts only when the mode was off.
            if (!copy_on) begin
                bs_odd = 1'b0;
                marker_step = MK_EMPTY;
            end
            copy_on = 1'b1;
        end else if (copy_on) begin
            r.out_byte = b;
            if (b == CH_NL && !bs_odd) begin
                r.line_end = 1'b1;
                if (marker_step == MK_DOT) begin
                    r.done = 1'b1;
                    copy_on = 1'b0;
                end
                marker_step = MK_EMPTY;
                bs_odd = 1'b0;
            end else if (b == CH_BSLASH) begin
                bs_odd = ~bs_odd;
                marker_step = (marker_step == MK_EMPTY) ? MK_SLASH : MK_OTHER;
            end else begin
                // Escaped newline lands here too: it disqualifies the marker line.
                bs_odd = 1'b0;
                marker_step = (b == CH_DOT && marker_step == MK_SLASH) ? MK_DOT : MK_OTHER;
            end
        end else begin
            r.out_byte = b;
            case (lex_mode)
                LX_SCAN: begin
                    if (b == CH_SEMI && nest_depth == '0) begin
                        r.stmt_end = 1'b1;
                    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        lex_mode = LX_QUOTE;
                        quote_char = b;
                        quote_esc = 1'b0;
                    end else if (b == CH_DASH && last_sql_byte == CH_DASH) begin
                        lex_mode = LX_LINEC;
                    end else if (b == CH_STAR && last_sql_byte == CH_SLASH) begin
                        lex_mode = LX_BLOCK;
                    end else if (b == CH_LPAR) begin
                        if (nest_depth == {DEPTH_BITS{1'b1}}) r.ovf = 1'b1;
                        else nest_depth = nest_depth + 1'b1;
                    end else if (b == CH_RPAR) begin
                        if (nest_depth == '0) r.ovf = 1'b1;
                        else nest_depth = nest_depth - 1'b1;
                    end
                end
                LX_LINEC: begin
                    if (b == CH_NL) lex_mode = LX_SCAN;
                end
                LX_BLOCK: begin
                    // The opening star may also close the comment.
                    if (last_sql_byte == CH_STAR && b == CH_SLASH) lex_mode = LX_SCAN;
                end
                default: begin
                    if (!quote_esc && quote_char == b) begin
                        lex_mode = LX_SCAN;
                    end else if (b == CH_BSLASH) begin
                        quote_esc = (last_sql_byte == CH_BSLASH) ? ~quote_esc : 1'b1;
                    end else begin
                        quote_esc = 1'b0;
                    end
                end
            endcase
            last_sql_byte = b;
        end
        r.copy_act = copy_on;
        r.lex = lex_mode;
        r.last = last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    task automatic push_req(input logic cmd, input logic [7:0] b, input logic chunk);
        t_req q;
        q.cmd = cmd;
        q.data = b;
        q.chunk = chunk;
        pending_reqs.push_back(q);
        reqs_queued++;
    endtask

    // Script byte; chunk boundary on roughly one byte in eight.
    task automatic push_byte(input logic [7:0] b);
        push_req(1'b0, b, ($urandom_range(0, 7) == 0));
    endtask

    // Copy entry; data byte is don't-care so it is randomized.
    task automatic push_copy_cmd();
        push_req(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Plain line, then the marker line: leaves copy mode from any copy state.
    task automatic push_copy_exit();
        push_byte(8'h78);
        push_byte(CH_NL);
        push_byte(CH_BSLASH);
        push_byte(CH_DOT);
        push_byte(CH_NL);
    endtask

    function automatic logic [7:0] pick_sql_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1, 2: c = 8'h61 + 8'($urandom_range(0, 25));
            3:       c = 8'h20;
            4:       c = CH_SEMI;
            5:       c = CH_LPAR;
            6:       c = CH_RPAR;
            7:       c = CH_SQUOTE;
            8:       c = CH_DQUOTE;
            9:       c = CH_BSLASH;
            10:      c = CH_DASH;
            11:      c = CH_SLASH;
            12:      c = CH_STAR;
            13:      c = CH_NL;
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_copy_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2: c = CH_BSLASH;
            3, 4:    c = CH_DOT;
            5:       c = CH_NL;
            6:       c = 8'h61 + 8'($urandom_range(0, 25));
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (calm) return 0;
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents pending requests at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req q;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !req_took) begin
            // hold the request until it is taken
        end else begin
            req_took = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                q = pending_reqs.pop_front();
                i_cmd <= q.cmd;
                i_data_byte <= q.data;
                i_chunk_end <= q.chunk;
                i_in_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, also changed at the falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: request acceptance, result checking and the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_split_res e;
        bit moved;
        moved = 1'b0;
        cycle_cnt++;
        // quiet windows with no idling on either side
        calm = ((cycle_cnt % 700) < 120);
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_split(i_cmd, i_data_byte, i_chunk_end));
                reqs_taken++;
                req_took = 1'b1;
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_out_byte !== e.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", e.out_byte, o_out_byte);
                        error_count++;
                    end
                    if (o_statement_end !== e.stmt_end) begin
                        $error("statement_end: expected %0b, got %0b",
                               e.stmt_end, o_statement_end);
                        error_count++;
                    end
                    if (o_copy_line_end !== e.line_end) begin
                        $error("copy_line_end: expected %0b, got %0b",
                               e.line_end, o_copy_line_end);
                        error_count++;
                    end
                    if (o_copy_done !== e.done) begin
                        $error("copy_done: expected %0b, got %0b", e.done, o_copy_done);
                        error_count++;
                    end
                    if (o_copy_active !== e.copy_act) begin
                        $error("copy_active: expected %0b, got %0b", e.copy_act, o_copy_active);
                        error_count++;
                    end
                    if (o_lexer_state !== e.lex) begin
                        $error("lexer_state: expected %0d, got %0d", e.lex, o_lexer_state);
                        error_count++;
                    end
                    if (o_depth_overflow !== e.ovf) begin
                        $error("depth_overflow: expected %0b, got %0b", e.ovf, o_depth_overflow);
                        error_count++;
                    end
                    if (o_chunk_last !== e.last) begin
                        $error("chunk_last: expected %0b, got %0b", e.last, o_chunk_last);
                        error_count++;
                    end
                    if (e.stmt_end) stmt_ends_seen++;
                    if (e.line_end) copy_lines_seen++;
                    if (e.done) copy_exits_seen++;
                    if (e.ovf) overflows_seen++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run.
    // ------------------------------------------------------------------
    initial begin
        int unsigned len;
        int unsigned n;

        // Directed: statement end, nesting, underflow, quotes with escapes.
        push_byte(CH_SEMI);
        push_byte(CH_LPAR);
        push_byte(CH_SEMI);      // nested, no end
        push_byte(CH_RPAR);
        push_byte(CH_RPAR);      // close at depth zero
        push_byte(CH_SEMI);
        push_byte(CH_SQUOTE);
        push_byte(CH_BSLASH);
        push_byte(CH_SQUOTE);    // escaped quote stays inside
        push_byte(CH_SQUOTE);
        push_byte(CH_DQUOTE);
        push_byte(CH_SQUOTE);    // other quote kind inside
        push_byte(CH_DQUOTE);
        // Line comment swallows the semicolon.
        push_byte(CH_DASH);
        push_byte(CH_DASH);
        push_byte(CH_SEMI);
        push_byte(CH_NL);
        // Block comment closed by the star that opened it.
        push_byte(CH_SLASH);
        push_byte(CH_STAR);
        push_byte(CH_SLASH);
        // Copy mode: repeated entry, escaped newline, plain line, marker line.
        push_copy_cmd();
        push_copy_cmd();
        push_byte(CH_BSLASH);
        push_byte(CH_NL);
        push_byte(CH_NL);
        push_byte(CH_BSLASH);
        push_byte(CH_DOT);
        push_byte(CH_NL);
        push_req(1'b0, 8'hFF, 1'b1);
        push_req(1'b0, 8'h00, 1'b0);

        // Nest to saturation and back below zero; state is plain scan here.
        repeat (257) push_byte(CH_LPAR);
        repeat (257) push_byte(CH_RPAR);
        push_byte(CH_SEMI);

        // Random script: mostly statements and copy blocks, some noise.
        while (reqs_queued < TARGET_REQS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    len = $urandom_range(1, 12);
                    for (n = 0; n < len; n++) push_byte(pick_sql_char());
                    push_byte(CH_SEMI);
                end
                10, 11, 12, 13, 14: begin
                    push_copy_cmd();
                    len = $urandom_range(0, 3);
                    for (n = 0; n < len; n++) begin
                        repeat ($urandom_range(0, 6)) push_byte(pick_copy_char());
                        push_byte(CH_NL);
                    end
                    push_copy_exit();
                end
                15, 16: begin
                    // balanced nesting around a statement body
                    len = $urandom_range(1, 6);
                    repeat (len) push_byte(CH_LPAR);
                    repeat ($urandom_range(0, 5)) push_byte(8'h61 + 8'($urandom_range(0, 25)));
                    push_byte(CH_SEMI);
                    repeat (len) push_byte(CH_RPAR);
                    push_byte(CH_SEMI);
                end
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        if ($urandom_range(0, 9) == 0) push_copy_cmd();
                        else push_req(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
                    end
                    push_copy_exit();
                end
            endcase
        end

        // Reset held from time zero, released on a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d requests, %0d results, %0d statement ends, %0d copy lines",
                 reqs_taken, results_seen, stmt_ends_seen, copy_lines_seen);
        $display("run: %0d copy exits, %0d depth saturations, %0d mismatches",
                 copy_exits_seen, overflows_seen, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
